// ----- rtl/s5hs_pkg.sv -----
// ----------------------------------------------------------------------------
// s5hs_pkg
// Shared types and constants of the SOCKS5 UDP datagram header stripper.
// ----------------------------------------------------------------------------
package s5hs_pkg;

	localparam logic [7:0] ATYP_IPV4   = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN = 8'h03;
	localparam logic [7:0] ATYP_IPV6   = 8'h04;

	localparam logic [8:0] HDR_LEN_IPV4        = 9'd10;
	localparam logic [8:0] HDR_LEN_IPV6        = 9'd22;
	localparam logic [8:0] HDR_LEN_DOMAIN_BASE = 9'd7;
	localparam logic [8:0] POS_MAX             = 9'd511;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_IPV4   = 2'd1;
	localparam logic [1:0] KIND_DOMAIN = 2'd2;
	localparam logic [1:0] KIND_IPV6   = 2'd3;

	localparam logic [2:0] ST_HEADER    = 3'd0;
	localparam logic [2:0] ST_PAYLOAD   = 3'd1;
	localparam logic [2:0] ST_FRAGMENT  = 3'd2;
	localparam logic [2:0] ST_MALFORMED = 3'd3;

	localparam logic [1:0] VERDICT_DELIVERED = 2'd0;
	localparam logic [1:0] VERDICT_FRAGMENT  = 2'd1;
	localparam logic [1:0] VERDICT_TRUNCATED = 2'd2;
	localparam logic [1:0] VERDICT_MALFORMED = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       frame_done;
		logic [1:0] verdict;
	} s5hs_entry_t;

endpackage

// ----- rtl/socks5_udp_datagram_header_stripper.sv -----
// ----------------------------------------------------------------------------
// socks5_udp_datagram_header_stripper
// Strips the SOCKS5 UDP relay header from a byte stream and gives a verdict.
// ----------------------------------------------------------------------------
// Takes one datagram byte per transaction, with frame_end on the final byte,
// and accepts a byte in every cycle while the output side keeps up. Each byte
// is classified in the cycle it is accepted; a payload byte or a final byte
// makes one result, header bytes make none. Results pass through a
// four-entry queue and an output register, so a result is held in a queue
// slot and then in the output register before it appears, and input keeps
// flowing for up to five results while the output is stalled. verdict: 0
// delivered, 1 fragment dropped, 2 truncated, 3 malformed (close).
module socks5_udp_datagram_header_stripper import s5hs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic       frame_done,
	output logic [1:0] verdict
);

	logic        push;
	logic        pop;
	logic        queue_full;
	logic        not_empty;
	s5hs_entry_t push_entry;
	s5hs_entry_t head_entry;

	s5hs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.frame_end  (frame_end),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	s5hs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head_entry (head_entry)
	);

	s5hs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.not_empty     (not_empty),
		.head_entry    (head_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.frame_done    (frame_done),
		.verdict       (verdict)
	);

endmodule

// ----- rtl/s5hs_front.sv -----
// ----------------------------------------------------------------------------
// s5hs_front
// Accepts datagram bytes, tracks header parsing and classifies each byte.
// ----------------------------------------------------------------------------
module s5hs_front import s5hs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	input  logic        queue_full,
	output logic        push,
	output s5hs_entry_t push_entry
);

	logic [8:0] pos_q;
	logic [1:0] kind_q;
	logic [8:0] hlen_q;
	logic [2:0] status_q;

	logic [1:0] kind_n;
	logic [8:0] hlen_n;
	logic [2:0] status_n;
	logic [1:0] verdict_n;
	logic       emit_payload;
	logic       accept;

	assign in_ready     = !queue_full;
	assign accept       = in_valid && in_ready;
	assign emit_payload = (status_q == ST_PAYLOAD);

	always_comb begin
		kind_n   = kind_q;
		hlen_n   = hlen_q;
		status_n = status_q;
		if (status_q == ST_HEADER) begin
			if (pos_q < 9'd2) begin
				if (rx_byte != 8'd0)
					status_n = ST_MALFORMED;
			end else if (pos_q == 9'd2) begin
				if (rx_byte != 8'd0)
					status_n = ST_FRAGMENT;
			end else if (pos_q == 9'd3) begin
				if (rx_byte == ATYP_IPV4) begin
					kind_n = KIND_IPV4;
					hlen_n = HDR_LEN_IPV4;
				end else if (rx_byte == ATYP_IPV6) begin
					kind_n = KIND_IPV6;
					hlen_n = HDR_LEN_IPV6;
				end else if (rx_byte == ATYP_DOMAIN) begin
					kind_n = KIND_DOMAIN;
					hlen_n = 9'd0;
				end else begin
					status_n = ST_MALFORMED;
				end
			end else if (pos_q == 9'd4 && kind_q == KIND_DOMAIN) begin
				hlen_n = HDR_LEN_DOMAIN_BASE + {1'b0, rx_byte};
			end
			if (status_n == ST_HEADER && hlen_n != 9'd0 &&
			    ({1'b0, pos_q} + 10'd1) == {1'b0, hlen_n})
				status_n = ST_PAYLOAD;
		end
	end

	always_comb begin
		if (pos_q < 9'd3 || status_n == ST_MALFORMED)
			verdict_n = VERDICT_MALFORMED;
		else if (status_n == ST_FRAGMENT)
			verdict_n = VERDICT_FRAGMENT;
		else if (status_n == ST_PAYLOAD)
			verdict_n = VERDICT_DELIVERED;
		else
			verdict_n = VERDICT_TRUNCATED;
	end

	assign push                     = accept && (emit_payload || frame_end);
	assign push_entry.payload_valid = emit_payload;
	assign push_entry.payload_byte  = emit_payload ? rx_byte : 8'd0;
	assign push_entry.frame_done    = frame_end;
	assign push_entry.verdict       = frame_end ? verdict_n : VERDICT_DELIVERED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 9'd0;
			kind_q   <= KIND_NONE;
			hlen_q   <= 9'd0;
			status_q <= ST_HEADER;
		end else if (accept) begin
			if (frame_end) begin
				pos_q    <= 9'd0;
				kind_q   <= KIND_NONE;
				hlen_q   <= 9'd0;
				status_q <= ST_HEADER;
			end else begin
				if (pos_q < POS_MAX)
					pos_q <= pos_q + 9'd1;
				kind_q   <= kind_n;
				hlen_q   <= hlen_n;
				status_q <= status_n;
			end
		end
	end

endmodule

// ----- rtl/s5hs_queue.sv -----
// ----------------------------------------------------------------------------
// s5hs_queue
// Short register queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module s5hs_queue import s5hs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  s5hs_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output s5hs_entry_t head_entry
);

	s5hs_entry_t          slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty  = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/s5hs_back.sv -----
// ----------------------------------------------------------------------------
// s5hs_back
// Output register: drains the queue and holds a result until it is taken.
// ----------------------------------------------------------------------------
module s5hs_back import s5hs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        not_empty,
	input  s5hs_entry_t head_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        frame_done,
	output logic [1:0]  verdict
);

	logic        valid_q;
	s5hs_entry_t result_q;

	assign pop           = not_empty && (!valid_q || out_ready);
	assign out_valid     = valid_q;
	assign payload_valid = result_q.payload_valid;
	assign payload_byte  = result_q.payload_byte;
	assign frame_done    = result_q.frame_done;
	assign verdict       = result_q.verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			result_q <= head_entry;
	end

endmodule

// ----- rtl/s5hs_checker.sv -----
// ----------------------------------------------------------------------------
// s5hs_checker
// Port-level checks of the header stripper, bound to the top level.
// ----------------------------------------------------------------------------
module s5hs_checker import s5hs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] rx_byte,
	input logic       frame_end,
	input logic       out_valid,
	input logic       out_ready,
	input logic       payload_valid,
	input logic [7:0] payload_byte,
	input logic       frame_done,
	input logic [1:0] verdict
);

	// hold a waiting input transaction
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(rx_byte) && $stable(frame_end))
		else $error("waiting input changed");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_valid) &&
		$stable(payload_byte) && $stable(frame_done) && $stable(verdict))
		else $error("stalled result changed");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> frame_done && payload_byte == 8'd0)
		else $error("empty result");

	a_verdict_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> verdict == VERDICT_DELIVERED)
		else $error("verdict without frame end");

	a_payload_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid && frame_done |-> verdict == VERDICT_DELIVERED)
		else $error("payload in a dropped datagram");

endmodule

bind socks5_udp_datagram_header_stripper s5hs_checker u_s5hs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.rx_byte       (rx_byte),
	.frame_end     (frame_end),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.payload_valid (payload_valid),
	.payload_byte  (payload_byte),
	.frame_done    (frame_done),
	.verdict       (verdict)
);
